### hw/rtl/fsc_pkg.sv
package fsc_pkg;

    // Table geometry.
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);

    // Field widths of the request and result items.
    localparam int OP_W    = 2;
    localparam int INDEX_W = 6;
    localparam int IP_W    = 32;
    localparam int PORT_W  = 16;
    localparam int HINT_W  = 2;
    localparam int CODE_W  = 16;
    localparam int STAT_W  = 2;

    localparam int IN_DATA_W  = 184;
    localparam int OUT_DATA_W = 88;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CLASSIFY   = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE      = 2'd1;
    localparam logic [OP_W-1:0] OP_INVALIDATE = 2'd2;

    // Direction hints.
    localparam logic [HINT_W-1:0] HINT_CLIENT = 2'd0;
    localparam logic [HINT_W-1:0] HINT_SERVER = 2'd1;

    // Match status codes.
    localparam logic [STAT_W-1:0] STATUS_CLIENT = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_SERVER = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_MISS   = 2'd2;

    // Data returned by a hit, the key flag included.
    typedef struct packed {
        logic [CODE_W-1:0] flag;
        logic [CODE_W-1:0] l4;
        logic [CODE_W-1:0] l7;
        logic [CODE_W-1:0] app;
        logic [CODE_W-1:0] sys;
    } t_entry_data;

    // Table write, shared by the key store and the data memory.
    typedef struct packed {
        logic                we;
        logic [IDX_W-1:0]    idx;
        t_entry_data         data;
    } t_wr_req;

    // Match vectors of the four probes.
    typedef struct packed {
        logic [ENTRIES-1:0] src_exact;
        logic [ENTRIES-1:0] src_wild;
        logic [ENTRIES-1:0] dst_exact;
        logic [ENTRIES-1:0] dst_wild;
    } t_probe_hits;

    // Registered lookup handed from the match stage to the select stage.
    typedef struct packed {
        logic                valid;
        logic [HINT_W-1:0]   hint;
        t_probe_hits         hits;
    } t_lookup;

endpackage

### hw/rtl/fsc_match.sv
module fsc_match
    import fsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  t_wr_req             i_wr,
    input  logic                i_inval,
    input  logic                i_classify,
    input  logic [IP_W-1:0]     i_src_ip,
    input  logic [PORT_W-1:0]   i_src_port,
    input  logic [IP_W-1:0]     i_dst_ip,
    input  logic [PORT_W-1:0]   i_dst_port,
    input  logic [HINT_W-1:0]   i_hint,
    input  logic [CODE_W-1:0]   i_sys_flag,
    output t_lookup             o_lookup
);

    logic [ENTRIES-1:0] r_entry_valid;
    logic [IP_W-1:0]    r_key_ip   [ENTRIES];
    logic [PORT_W-1:0]  r_key_port [ENTRIES];
    logic [CODE_W-1:0]  r_key_flag [ENTRIES];
    t_lookup            r_lookup;
    t_probe_hits        n_hits;

    // Valid bits: set by a write, cleared by an invalidate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
        end else if (i_wr.we) begin
            r_entry_valid[i_wr.idx] <= 1'b1;
        end else if (i_inval) begin
            r_entry_valid[i_wr.idx] <= 1'b0;
        end
    end

    // Key store.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_key_ip[i_wr.idx]   <= i_src_ip;
            r_key_port[i_wr.idx] <= i_src_port;
            r_key_flag[i_wr.idx] <= i_wr.data.flag;
        end
    end

    // Every entry is compared against all four probe keys at once.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_hits.src_exact[i] = r_entry_valid[i] && r_key_flag[i] == i_sys_flag &&
                                  r_key_ip[i] == i_src_ip && r_key_port[i] == i_src_port;
            n_hits.src_wild[i]  = r_entry_valid[i] && r_key_flag[i] == i_sys_flag &&
                                  r_key_ip[i] == i_src_ip && r_key_port[i] == '0;
            n_hits.dst_exact[i] = r_entry_valid[i] && r_key_flag[i] == i_sys_flag &&
                                  r_key_ip[i] == i_dst_ip && r_key_port[i] == i_dst_port;
            n_hits.dst_wild[i]  = r_entry_valid[i] && r_key_flag[i] == i_sys_flag &&
                                  r_key_ip[i] == i_dst_ip && r_key_port[i] == '0;
        end
    end

    // Lookup register; only its valid flag is reset.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lookup.hint <= i_hint;
            r_lookup.hits <= n_hits;
        end
        if (!i_rst_n) begin
            r_lookup.valid <= 1'b0;
        end else if (i_adv) begin
            r_lookup.valid <= i_classify;
        end
    end

    assign o_lookup = r_lookup;

`ifndef NO_ASSERTIONS
    // A table write leaves its slot valid.
    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.we |=> r_entry_valid[$past(i_wr.idx)])
        else $error("written slot is not valid");

    // An invalidate leaves its slot invalid.
    a_inval_clears_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_inval && !i_wr.we |=> !r_entry_valid[$past(i_wr.idx)])
        else $error("invalidated slot is still valid");

    // Table updates and lookups never share a cycle.
    a_update_xor_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_wr.we, i_inval, i_classify}))
        else $error("table update during a lookup");
`endif

endmodule

### hw/rtl/fsc_select.sv
module fsc_select
    import fsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  t_wr_req               i_wr,
    input  t_lookup               i_lookup,
    output logic                  o_valid,
    output logic [OUT_DATA_W-1:0] o_data
);

    t_entry_data        r_mem [ENTRIES];
    t_entry_data        r_rd_data;
    logic               r_valid;
    logic [STAT_W-1:0]  r_status;
    logic [ENTRIES-1:0] n_vec;
    logic [STAT_W-1:0]  n_status;
    logic [IDX_W-1:0]   n_idx;
    logic [ENTRIES-1:0] w_src_vec;
    logic [ENTRIES-1:0] w_dst_vec;
    logic               w_src_en;
    logic               w_dst_en;
    t_entry_data        w_codes;

    // Each side takes its exact-port hits before its wildcard hits.
    assign w_src_vec = (|i_lookup.hits.src_exact) ? i_lookup.hits.src_exact
                                                  : i_lookup.hits.src_wild;
    assign w_dst_vec = (|i_lookup.hits.dst_exact) ? i_lookup.hits.dst_exact
                                                  : i_lookup.hits.dst_wild;
    assign w_src_en  = i_lookup.hint != HINT_CLIENT;
    assign w_dst_en  = i_lookup.hint != HINT_SERVER;

    // The hint enables one side only; an unknown hint tries both sides, the source first.
    always_comb begin
        if (w_src_en && (|w_src_vec)) begin
            n_vec    = w_src_vec;
            n_status = STATUS_SERVER;
        end else if (w_dst_en && (|w_dst_vec)) begin
            n_vec    = w_dst_vec;
            n_status = STATUS_CLIENT;
        end else begin
            n_vec    = '0;
            n_status = STATUS_MISS;
        end
    end

    // The lowest matching slot wins.
    always_comb begin
        n_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (n_vec[i]) begin
                n_idx = IDX_W'(i);
            end
        end
    end

    // Data memory with registered read; a read in the same cycle as a write sees old data.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        if (i_adv) begin
            r_rd_data <= r_mem[n_idx];
            r_status  <= n_status;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_lookup.valid;
        end
    end

    // A miss returns all codes as zero.
    assign w_codes = (r_status != STATUS_MISS) ? r_rd_data : '0;
    assign o_valid = r_valid;
    assign o_data  = {{(OUT_DATA_W - STAT_W - 5 * CODE_W){1'b0}},
                      w_codes.sys, w_codes.flag, w_codes.app, w_codes.l7, w_codes.l4,
                      r_status};

`ifndef NO_ASSERTIONS
    // A client hint never yields a server-side hit.
    a_client_hint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_lookup.valid && i_lookup.hint == HINT_CLIENT
        |=> r_status != STATUS_SERVER)
        else $error("server hit on a client hint");

    // A server hint never yields a client-side hit.
    a_server_hint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_lookup.valid && i_lookup.hint == HINT_SERVER
        |=> r_status != STATUS_CLIENT)
        else $error("client hit on a server hint");
`endif

endmodule

### hw/rtl/flow_service_classifier.sv
// A request passes through the input register, the lookup register and the result register to o_m_tvalid.
// Throughput: one request per cycle while no result is stalled; each of the three register stages holds one request.
// A stalled result holds every stage, and o_s_tready then drops.
// Write and invalidate requests update the table and give no result.
// Reset (i_rst_n low at a clock edge) clears all entry valid bits, the stage
// valid flags and the system flag register.
module flow_service_classifier
    import fsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request stream.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // entry_index, src_ip, src_port, dst_ip, dst_port, direction_hint,
    // entry_flag, l4_code_in, l7_code_in, app_code_in, sys_type_in
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // operation
    input  logic [OP_W-1:0]       i_s_tuser,
    // Result stream.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // match_status, l4_code, l7_code, app_code, flag_code, sys_type, zero fill
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // System flag register.
    input  logic                  i_cfg_we,
    input  logic [CODE_W-1:0]     i_cfg_wdata
);

    logic                r_s1_valid;
    logic [OP_W-1:0]     r_s1_op;
    logic [IN_DATA_W-1:0] r_s1_data;
    logic [CODE_W-1:0]   r_sys_flag;
    logic                w_adv;
    logic                w_in_range;
    logic [INDEX_W-1:0]  w_index;
    t_wr_req             w_wr;
    logic                w_inval;
    logic                w_classify;
    t_lookup             w_lookup;

    // All stages move together unless a finished result is waiting.
    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv;

    // System flag register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys_flag <= '0;
        end else if (i_cfg_we) begin
            r_sys_flag <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_op   <= i_s_tuser;
            r_s1_data <= i_s_tdata;
        end
    end

    // Decode of the registered request.
    assign w_index    = r_s1_data[5:0];
    assign w_in_range = int'(w_index) < ENTRIES;
    assign w_classify = w_adv && r_s1_valid && r_s1_op == OP_CLASSIFY;
    assign w_inval    = w_adv && r_s1_valid && r_s1_op == OP_INVALIDATE && w_in_range;

    assign w_wr.we        = w_adv && r_s1_valid && r_s1_op == OP_WRITE && w_in_range;
    assign w_wr.idx       = IDX_W'(w_index);
    assign w_wr.data.flag = r_s1_data[119:104];
    assign w_wr.data.l4   = r_s1_data[135:120];
    assign w_wr.data.l7   = r_s1_data[151:136];
    assign w_wr.data.app  = r_s1_data[167:152];
    assign w_wr.data.sys  = r_s1_data[183:168];

    fsc_match u_match (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_wr       (w_wr),
        .i_inval    (w_inval),
        .i_classify (w_classify),
        .i_src_ip   (r_s1_data[37:6]),
        .i_src_port (r_s1_data[53:38]),
        .i_dst_ip   (r_s1_data[85:54]),
        .i_dst_port (r_s1_data[101:86]),
        .i_hint     (r_s1_data[103:102]),
        .i_sys_flag (r_sys_flag),
        .o_lookup   (w_lookup)
    );

    fsc_select u_select (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_wr     (w_wr),
        .i_lookup (w_lookup),
        .o_valid  (o_m_tvalid),
        .o_data   (o_m_tdata)
    );

endmodule
